// ----- hw/rtl/gda_pkg.sv -----
// Shared constants and the month-length function for the Gregorian date adder.
package gda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AddDW  = 16;
  localparam int unsigned AddMW  = 12;
  localparam int unsigned AddYW  = 12;

  // Working year needs one more bit than the port: carries may pass 16383.
  localparam int unsigned WorkYearW = YearW + 1;
  // Start day plus added days fits in this width.
  localparam int unsigned WorkDayW  = AddDW + 1;
  localparam int unsigned SubW      = WorkDayW;

  localparam logic [MonthW-1:0] MonJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);
  localparam logic [MonthW-1:0] MonDec = MonthW'(12);

  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned LeapCycle     = 400;

  function automatic logic [DayW-1:0] month_len(input logic leap,
                                                input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      MonFeb:                          len = leap ? DayW'(29) : DayW'(28);
      MonApr, MonJun, MonSep, MonNov:  len = DayW'(30);
      default:                         len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/gda_in_if.sv -----
// Input channel: start date and the counts to add.
interface gda_in_if;
  import gda_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   start_day;
  logic [MonthW-1:0] start_month;
  logic [YearW-1:0]  start_year;
  logic [AddDW-1:0]  add_days;
  logic [AddMW-1:0]  add_months;
  logic [AddYW-1:0]  add_years;

  modport source (output valid, start_day, start_month, start_year,
                  add_days, add_months, add_years, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  add_days, add_months, add_years, output ready);
endinterface

// ----- hw/rtl/gda_out_if.sv -----
// Output channel: resulting date.
interface gda_out_if;
  import gda_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   result_day;
  logic [MonthW-1:0] result_month;
  logic [YearW-1:0]  result_year;

  modport source (output valid, result_day, result_month, result_year, input ready);
  modport sink   (input valid, result_day, result_month, result_year, output ready);
endinterface

// ----- hw/rtl/gregorian_date_adder_top.sv -----
// Gregorian date adder: start date plus days, then months, then years.
//
// One date at a time. After a beat is taken the block runs one shared
// subtractor under a small sequencer: first it reduces the start year
// modulo 400 to track the leap rule as the year carries, then it takes
// away one month length per cycle until the day fits, then it steps
// whole years out of the added months, 12 per cycle, then settles the
// month and rolls any day overflow, and adds the years while writing
// the result. The input is ready only when the sequencer is idle; the
// result sits in an output register until taken.
module gregorian_date_adder_top (
  input  logic      clk,
  input  logic      rst,
  gda_in_if.sink    din,
  gda_out_if.source dout
);
  import gda_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_DAYS  = 7'b0000100,
    S_MSTEP = 7'b0001000,
    S_MFIX  = 7'b0010000,
    S_ROLL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state;
  logic [WorkDayW-1:0]  day;
  logic [MonthW-1:0]    month;
  logic [WorkYearW-1:0] year;
  logic [WorkYearW-1:0] ymod;
  logic [AddMW-1:0]     rem;
  logic [AddYW-1:0]     nyears;

  logic [SubW-1:0]      sub_a;
  logic [SubW-1:0]      sub_b;
  logic [SubW:0]        diff;
  logic                 borrow;
  logic                 leap;
  logic [DayW-1:0]      len;
  logic                 day_fits;
  logic [DayW-1:0]      start_d;
  logic [MonthW-1:0]    start_m;
  logic [DayW-1:0]      mtot;
  logic [YearW-1:0]     year_sum;

  // ymod holds year mod 400 once the initial reduction is done.
  assign leap = (ymod[1:0] == 2'b00) && (ymod != WorkYearW'(100)) &&
                (ymod != WorkYearW'(200)) && (ymod != WorkYearW'(300));
  assign len  = month_len(leap, month);

  // Shared subtractor.
  always_comb begin
    case (state)
      S_INIT: begin
        sub_a = SubW'(ymod);
        sub_b = SubW'(LeapCycle);
      end
      S_DAYS, S_ROLL: begin
        sub_a = day;
        sub_b = SubW'(len);
      end
      S_MSTEP: begin
        sub_a = SubW'(rem);
        sub_b = SubW'(MonthsPerYear);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = diff[SubW];
  assign day_fits = borrow || (diff[SubW-1:0] == '0);

  assign start_d  = (din.start_day == '0) ? DayW'(1) : din.start_day;
  assign start_m  = (din.start_month == '0) ? MonJan :
                    (din.start_month > MonDec) ? MonDec : din.start_month;

  // Zero-based month plus leftover months, below 23.
  assign mtot     = DayW'(month) - DayW'(1) + DayW'(rem);
  assign year_sum = YearW'(year) + YearW'(nyears);

  assign din.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dout.valid <= 1'b0;
    end else begin
      // S_DONE drives the output register itself.
      if (dout.valid && dout.ready && (state != S_DONE)) begin
        dout.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            day    <= WorkDayW'(start_d) + WorkDayW'(din.add_days);
            month  <= start_m;
            year   <= WorkYearW'(din.start_year);
            ymod   <= WorkYearW'(din.start_year);
            rem    <= din.add_months;
            nyears <= din.add_years;
            state  <= S_INIT;
          end
        end
        S_INIT: begin
          if (borrow) begin
            state <= S_DAYS;
          end else begin
            ymod <= diff[WorkYearW-1:0];
          end
        end
        S_DAYS, S_ROLL: begin
          if (day_fits) begin
            state <= (state == S_DAYS) ? S_MSTEP : S_DONE;
          end else begin
            day <= diff[SubW-1:0];
            if (month == MonDec) begin
              month <= MonJan;
              year  <= year + WorkYearW'(1);
              ymod  <= (ymod == WorkYearW'(LeapCycle - 1)) ? '0 : ymod + WorkYearW'(1);
            end else begin
              month <= month + MonthW'(1);
            end
          end
        end
        S_MSTEP: begin
          if (borrow) begin
            state <= S_MFIX;
          end else begin
            rem  <= diff[AddMW-1:0];
            year <= year + WorkYearW'(1);
            ymod <= (ymod == WorkYearW'(LeapCycle - 1)) ? '0 : ymod + WorkYearW'(1);
          end
        end
        S_MFIX: begin
          if (mtot >= DayW'(MonthsPerYear)) begin
            month <= MonthW'(mtot - DayW'(MonthsPerYear - 1));
            year  <= year + WorkYearW'(1);
            ymod  <= (ymod == WorkYearW'(LeapCycle - 1)) ? '0 : ymod + WorkYearW'(1);
          end else begin
            month <= MonthW'(mtot + DayW'(1));
          end
          state <= S_ROLL;
        end
        S_DONE: begin
          // Hold until the output register is free.
          if (!dout.valid || dout.ready) begin
            dout.valid        <= 1'b1;
            dout.result_day   <= day[DayW-1:0];
            dout.result_month <= month;
            dout.result_year  <= year_sum;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/gregorian_date_adder_top_tb.sv -----
// Self-checking testbench for the Gregorian date adder: random and corner dates vs. a predictor.
module gregorian_date_adder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gda_pkg::*;

  typedef struct {
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [YearW-1:0]  start_year;
    logic [AddDW-1:0]  add_days;
    logic [AddMW-1:0]  add_months;
    logic [AddYW-1:0]  add_years;
    int unsigned       gap;
    bit                drain;
  } date_req_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gda_in_if  din_if ();
  gda_out_if dout_if ();

  gregorian_date_adder_top u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #10 clk = ~clk;

  date_req_t   date_req_q[$];
  date_t       sum_date_q[$];
  date_req_t   on_wire;
  int unsigned n_reqs;
  int unsigned dates_sent;
  int unsigned dates_checked;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          gap_armed;
  bit          failed;
  logic        hold_off;

  function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mo);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % LeapCycle == 0);
    if (mo == MonFeb) return leap ? 29 : 28;
    if (mo == MonApr || mo == MonJun || mo == MonSep || mo == MonNov) return 30;
    return 31;
  endfunction

  // Take away whole months until the day fits, carrying month and year.
  function automatic void settle_day(inout int unsigned d, inout int unsigned m,
                                     inout int unsigned y);
    while (d > days_in_month(y, m)) begin
      d = d - days_in_month(y, m);
      m++;
      if (m > MonDec) begin
        m = MonJan;
        y++;
      end
    end
  endfunction

  function automatic date_t date_after_add(input date_req_t r);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned total;
    date_t res;
    d = (r.start_day == 0) ? 1 : r.start_day;
    m = r.start_month;
    if (m == 0) m = MonJan;
    if (m > MonDec) m = MonDec;
    y = r.start_year;
    d = d + r.add_days;
    settle_day(d, m, y);
    total = (m - 1) + r.add_months;
    y = y + total / MonthsPerYear;
    m = total % MonthsPerYear + 1;
    settle_day(d, m, y);
    y = y + r.add_years;
    res.day   = DayW'(d);
    res.month = MonthW'(m);
    res.year  = YearW'(y);
    return res;
  endfunction

  task automatic queue_date(input int unsigned d, input int unsigned m, input int unsigned y,
                            input int unsigned nd, input int unsigned nm,
                            input int unsigned ny, input bit drain);
    date_req_t r;
    r.start_day   = DayW'(d);
    r.start_month = MonthW'(m);
    r.start_year  = YearW'(y);
    r.add_days    = AddDW'(nd);
    r.add_months  = AddMW'(nm);
    r.add_years   = AddYW'(ny);
    // every few dozen beats, send back to back
    r.gap   = (date_req_q.size() % 50 < 12) ? 0 : $urandom_range(0, 6);
    r.drain = drain;
    date_req_q.push_back(r);
    n_reqs++;
  endtask

  // Driver: one beat at a time from the pending queue.
  always @(posedge clk) begin
    logic offering;
    if (rst) begin
      din_if.valid <= 1'b0;
      gap_armed = 1'b0;
    end else begin
      offering = din_if.valid;
      if (din_if.valid && din_if.ready) begin
        sum_date_q.push_back(date_after_add(on_wire));
        dates_sent++;
        offering = 1'b0;
      end
      if (!offering && date_req_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = date_req_q[0].gap;
          gap_armed = 1'b1;
        end
        // hold a draining beat until all outstanding dates are back
        if (!(date_req_q[0].drain && sum_date_q.size() > 0)) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            on_wire   = date_req_q.pop_front();
            gap_armed = 1'b0;
            offering  = 1'b1;
            din_if.start_day   <= on_wire.start_day;
            din_if.start_month <= on_wire.start_month;
            din_if.start_year  <= on_wire.start_year;
            din_if.add_days    <= on_wire.add_days;
            din_if.add_months  <= on_wire.add_months;
            din_if.add_years   <= on_wire.add_years;
          end
        end
      end
      din_if.valid <= offering;
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk) begin
    date_t want;
    if (rst) begin
      dout_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (dout_if.valid && dout_if.ready) begin
        if (sum_date_q.size() == 0) begin
          $error("unexpected result: day %0d month %0d year %0d",
                 dout_if.result_day, dout_if.result_month, dout_if.result_year);
          failed = 1'b1;
        end else begin
          want = sum_date_q.pop_front();
          if (dout_if.result_day !== want.day) begin
            $error("result_day: expected %0d, got %0d", want.day, dout_if.result_day);
            failed = 1'b1;
          end
          if (dout_if.result_month !== want.month) begin
            $error("result_month: expected %0d, got %0d", want.month, dout_if.result_month);
            failed = 1'b1;
          end
          if (dout_if.result_year !== want.year) begin
            $error("result_year: expected %0d, got %0d", want.year, dout_if.result_year);
            failed = 1'b1;
          end
        end
        dates_checked++;
        stall_left = (dates_checked % 64 < 16) ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      dout_if.ready <= (stall_left == 0) && !hold_off;
    end
  end

  // Long receiver hold-off: the block finishes its date and then stalls its input.
  initial begin
    hold_off = 1'b0;
    wait (dates_checked >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (6000) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #80_000_000;
    $display("[gregorian_date_adder_top] ERROR");
    $finish;
  end

  initial begin
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned nd;
    din_if.valid       = 1'b0;
    din_if.start_day   = '0;
    din_if.start_month = '0;
    din_if.start_year  = '0;
    din_if.add_days    = '0;
    din_if.add_months  = '0;
    din_if.add_years   = '0;
    dout_if.ready      = 1'b0;
    failed        = 1'b0;
    n_reqs        = 0;
    dates_sent    = 0;
    dates_checked = 0;

    // corner dates
    queue_date(1, 1, 1, 0, 0, 0, 0);
    queue_date(31, 12, 9999, 0, 0, 0, 0);
    queue_date(31, 12, 1999, 1, 0, 0, 0);          // year rollover
    queue_date(28, 2, 2000, 1, 0, 0, 0);           // leap by 400
    queue_date(28, 2, 1900, 1, 0, 0, 0);           // century not leap
    queue_date(28, 2, 2024, 1, 0, 0, 0);
    queue_date(29, 2, 2024, 0, 0, 1, 0);           // 29 Feb kept after years
    queue_date(31, 1, 2023, 0, 1, 0, 0);           // day rolls past February
    queue_date(31, 1, 2024, 0, 1, 0, 0);
    queue_date(0, 5, 2010, 0, 0, 0, 0);            // day zero
    queue_date(10, 0, 2010, 0, 0, 0, 0);           // month zero
    queue_date(10, 13, 2010, 0, 0, 0, 0);          // month above twelve
    queue_date(31, 15, 2010, 3, 0, 0, 0);
    queue_date(31, 2, 2011, 0, 0, 0, 0);           // day beyond month length
    queue_date(31, 4, 2011, 0, 0, 0, 0);
    queue_date(1, 3, 0, 0, 0, 0, 0);               // year zero
    queue_date(29, 2, 0, 365, 0, 0, 0);
    queue_date(15, 6, 16383, 0, 0, 0, 0);
    queue_date(31, 12, 16383, 1, 0, 0, 0);         // year wraps
    queue_date(31, 12, 16383, 65535, 4095, 4095, 0);
    queue_date(1, 1, 1, 65535, 0, 0, 0);
    queue_date(1, 1, 9999, 0, 4095, 0, 0);
    queue_date(1, 1, 9999, 0, 0, 4095, 0);
    queue_date(31, 31, 16383, 65535, 4095, 4095, 0);

    // random part, with two full drains along the way
    for (int i = 0; i < 216; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        m = $urandom_range(1, 12);
        d = $urandom_range(1, 31);
        case ($urandom_range(0, 3))
          0:       y = $urandom_range(1, 9999);
          1:       y = $urandom_range(1, 99) * 100 + $urandom_range(0, 4) - 2;
          2:       y = $urandom_range(1, 24) * 400 - $urandom_range(0, 1);
          default: y = $urandom_range(1900, 2100);
        endcase
      end else begin
        d = $urandom_range(0, 31);
        m = $urandom_range(0, 15);
        y = $urandom_range(0, 16383);
      end
      case ($urandom_range(0, 3))
        0:       nd = $urandom_range(0, 65535);
        1:       nd = $urandom_range(0, 1500);
        2:       nd = $urandom_range(0, 60);
        default: nd = 0;
      endcase
      queue_date(d, m, y, nd, $urandom_range(0, 4095) >> $urandom_range(0, 11),
                 $urandom_range(0, 4095) >> $urandom_range(0, 11),
                 (i == 0) || (i == 120));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (dates_sent != n_reqs) @(posedge clk);
    while (sum_date_q.size() != 0) @(posedge clk);
    repeat (2600) @(posedge clk);

    if (!failed) begin
      $display("[gregorian_date_adder_top] OK");
    end else begin
      $display("[gregorian_date_adder_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gda_pkg.sv
hw/rtl/gda_in_if.sv
hw/rtl/gda_out_if.sv
hw/rtl/gregorian_date_adder_top.sv
sim/gregorian_date_adder_top_tb.sv
